// ===== rtl/pfsb_pkg.sv =====
// Shared constants, types and address helper for the page frame buffer blitter.
`default_nettype none

package pfsb_pkg;

  localparam int SCREEN_WIDTH   = 128;
  localparam int SCREEN_HEIGHT  = 64;
  localparam int COLLISION_BITS = 32;
  localparam int PAGE_ROWS      = 8;
  localparam int PAGES          = SCREEN_HEIGHT / PAGE_ROWS;
  localparam int FB_DEPTH       = SCREEN_WIDTH * PAGES;
  localparam int FB_AW          = $clog2(FB_DEPTH);

  // Operation codes.
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Color modes; MODE_KEEP leaves the cell unchanged and only tests for overlap.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;
  localparam logic [1:0] MODE_KEEP   = 2'd3;

  // Placement of one sprite byte over its two buffer cells.
  typedef struct packed {
    logic             vld0;
    logic             vld1;
    logic [FB_AW-1:0] addr0;
    logic [FB_AW-1:0] addr1;
    logic [7:0]       bits0;
    logic [7:0]       bits1;
  } geom_t;

  // Write port of the frame buffer.
  typedef struct packed {
    logic             we;
    logic [FB_AW-1:0] addr;
    logic [7:0]       data;
  } fb_wr_t;

  function automatic logic [FB_AW-1:0] fb_addr(input logic [3:0] page, input logic [6:0] col);
    logic [10:0] a;
    a = 11'(page) * 11'(SCREEN_WIDTH) + 11'(col);
    return a[FB_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfsb_fbuf.sv =====
// Frame buffer memory: one write port, one read port with registered data.
`default_nettype none

module pfsb_fbuf (
  input  logic                       clk_i,
  input  pfsb_pkg::fb_wr_t           wr_i,
  input  logic [pfsb_pkg::FB_AW-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);
  import pfsb_pkg::*;

  logic [7:0] mem_q [FB_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pfsb_geom.sv =====
// Placement of a sprite byte: clipping, page pair, column and shifted bit masks.
`default_nettype none

module pfsb_geom (
  input  logic signed [7:0] pos_x_i,
  input  logic signed [7:0] pos_y_i,
  input  logic [6:0]        sprite_w_i,
  input  logic [6:0]        sprite_h_i,
  input  logic              mirror_i,
  input  logic [6:0]        bitmap_col_i,
  input  logic [3:0]        bitmap_row_i,
  input  logic [7:0]        pixels_i,
  output pfsb_pkg::geom_t   geom_o
);
  import pfsb_pkg::*;

  localparam logic signed [8:0] Y_MAX   = 9'(SCREEN_HEIGHT - 1);
  localparam logic signed [6:0] PAGES_S = 7'(PAGES);

  logic signed [8:0] x9, y9, xw, yh, col;
  logic signed [4:0] base;
  logic signed [6:0] page0, page1;
  logic [6:0]        xcol;
  logic [2:0]        off;
  logic [15:0]       sh;
  logic              off_screen, outside, col_ok, ok, pg0_ok, pg1_ok;

  assign x9   = $signed({pos_x_i[7], pos_x_i});
  assign y9   = $signed({pos_y_i[7], pos_y_i});
  assign xw   = x9 + $signed({2'b00, sprite_w_i});
  assign yh   = y9 + $signed({2'b00, sprite_h_i});

  assign off_screen = xw[8] || yh[8] || (y9 > Y_MAX);
  // A band lies outside the sprite when band * 8 reaches the height.
  assign outside    = (bitmap_col_i >= sprite_w_i) ||
                      ({1'b0, bitmap_row_i, 3'b000} >= {1'b0, sprite_h_i});

  assign base  = $signed(pos_y_i[7:3]);
  assign page0 = $signed({{2{base[4]}}, base}) + $signed({3'b000, bitmap_row_i});
  assign page1 = page0 + 7'sd1;

  assign xcol   = mirror_i ? (sprite_w_i - 7'd1 - bitmap_col_i) : bitmap_col_i;
  assign col    = x9 + $signed({2'b00, xcol});
  assign col_ok = !col[8] && (col[7:0] < 8'(SCREEN_WIDTH));

  assign off = pos_y_i[2:0];
  assign sh  = {8'h00, pixels_i} << off;

  assign ok     = !off_screen && !outside && col_ok;
  assign pg0_ok = !page0[6] && (page0 < PAGES_S);
  assign pg1_ok = !page1[6] && (page1 < PAGES_S);

  assign geom_o.vld0  = ok && pg0_ok;
  assign geom_o.vld1  = ok && (off != 3'd0) && pg1_ok;
  assign geom_o.addr0 = fb_addr(page0[3:0], col[6:0]);
  assign geom_o.addr1 = fb_addr(page1[3:0], col[6:0]);
  assign geom_o.bits0 = sh[7:0];
  assign geom_o.bits1 = sh[15:8];

endmodule

`default_nettype wire

// ===== rtl/pfsb_blend.sv =====
// Shared read-modify-write unit: combines a mask into a buffer byte and reports overlap.
`default_nettype none

module pfsb_blend (
  input  logic [7:0] cell_i,
  input  logic [7:0] bits_i,
  input  logic [1:0] mode_i,
  output logic [7:0] cell_o,
  output logic       hit_o
);
  import pfsb_pkg::*;

  assign hit_o = (cell_i & bits_i) != 8'h00;

  always_comb begin
    case (mode_i)
      MODE_CLEAR:  cell_o = cell_i & ~bits_i;
      MODE_SET:    cell_o = cell_i | bits_i;
      MODE_INVERT: cell_o = cell_i ^ bits_i;
      default:     cell_o = cell_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/page_framebuffer_sprite_blitter.sv =====
// Top level: sequencer around the frame buffer and the shared blend unit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, operation_i..last_i | into block
//  out     | out_valid_o, out_ready_i, collision_mask_o,  | out of block
//          | white_found_o, read_data_o                   |
//
// After reset the whole buffer is swept to zero, one byte per cycle; in_ready_o
// stays low meanwhile. A draw byte is decoded, then read and written through the
// single memory port pair for each of its two pages; a last byte adds the
// response step. A readout is a read, a range check and the response step. A
// row query makes one memory read and one test per column examined, then a
// closing read and a response; a set pixel ends it early, skipping that read.
// Input is taken only in the idle state; a finished result waits in the output
// register without blocking the next transfer, and the block stalls only when
// a second result is ready before the first was taken.
`default_nettype none

module page_framebuffer_sprite_blitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [7:0] pos_y_i,
  input  logic [6:0]        sprite_w_i,
  input  logic [6:0]        sprite_h_i,
  input  logic [1:0]        color_mode_i,
  input  logic              mirror_i,
  input  logic [6:0]        bitmap_col_i,
  input  logic [3:0]        bitmap_row_i,
  input  logic [7:0]        pixels_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       collision_mask_o,
  output logic              white_found_o,
  output logic [7:0]        read_data_o
);
  import pfsb_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_RD0, ST_WR0, ST_RD1, ST_WR1,
    ST_QRD, ST_QCHK, ST_ORD, ST_OCHK, ST_RESP
  } state_e;

  state_e state_q;

  // Captured item.
  logic [1:0]        mode_q;
  logic signed [7:0] x_q, y_q;
  logic [6:0]        w_q, h_q, c_q;
  logic [3:0]        band_q;
  logic [7:0]        px_q;
  logic              mir_q, last_q;

  geom_t             geom, g_q;
  fb_wr_t            fb_wr;
  logic [FB_AW-1:0]  fb_raddr, clr_cnt_q, qaddr, oaddr;
  logic [7:0]        fb_rdata, blend_bits, blend_cell, qmask;
  logic [1:0]        blend_mode;
  logic              blend_hit, acc_hit, q_stop, o_in_range, out_free;
  logic [7:0]        qcol_q;
  logic [6:0]        qcnt_q;
  logic [COLLISION_BITS-1:0] coll_acc_q, coll_acc_d, hit_bit;

  // Pending result, moved into the output register in ST_RESP.
  logic [31:0]       res_coll_q;
  logic              res_white_q;
  logic [7:0]        res_read_q;

  logic [31:0]       coll_mask_q;
  logic              white_q, out_valid_q;
  logic [7:0]        read_data_q;

  pfsb_geom u_geom (
    .pos_x_i     (x_q),
    .pos_y_i     (y_q),
    .sprite_w_i  (w_q),
    .sprite_h_i  (h_q),
    .mirror_i    (mir_q),
    .bitmap_col_i(c_q),
    .bitmap_row_i(band_q),
    .pixels_i    (px_q),
    .geom_o      (geom)
  );

  pfsb_blend u_blend (
    .cell_i(fb_rdata),
    .bits_i(blend_bits),
    .mode_i(blend_mode),
    .cell_o(blend_cell),
    .hit_o (blend_hit)
  );

  pfsb_fbuf u_fbuf (
    .clk_i  (clk_i),
    .wr_i   (fb_wr),
    .raddr_i(fb_raddr),
    .rdata_o(fb_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Row query: the pixel row selects a page and one bit of each byte.
  assign qmask  = 8'h01 << y_q[2:0];
  assign qaddr  = fb_addr({1'b0, y_q[5:3]} | {y_q[6], 3'b000}, qcol_q[6:0]);
  assign q_stop = (y_q >= 8'(SCREEN_HEIGHT)) ||
                  ({5'b00000, y_q[7:3]} >= 10'(PAGES)) ||
                  (qcnt_q == 7'd0) || (qcol_q >= 8'(SCREEN_WIDTH));

  assign oaddr      = fb_addr(band_q, c_q);
  assign o_in_range = ({1'b0, band_q} < 5'(PAGES)) && ({1'b0, c_q} < 8'(SCREEN_WIDTH));

  assign blend_bits = (state_q == ST_WR1)  ? g_q.bits1 :
                      (state_q == ST_QCHK) ? qmask : g_q.bits0;
  assign blend_mode = (state_q == ST_QCHK) ? MODE_KEEP : mode_q;

  assign hit_bit    = {{(COLLISION_BITS-1){1'b0}}, 1'b1} << c_q;
  assign acc_hit    = blend_hit && (((state_q == ST_WR0) && g_q.vld0) ||
                                    ((state_q == ST_WR1) && g_q.vld1));
  assign coll_acc_d = coll_acc_q | (acc_hit ? hit_bit : '0);

  always_comb begin
    fb_wr.we   = 1'b0;
    fb_wr.addr = g_q.addr0;
    fb_wr.data = blend_cell;
    fb_raddr   = g_q.addr0;
    case (state_q)
      ST_CLEAR: begin
        fb_wr.we   = 1'b1;
        fb_wr.addr = clr_cnt_q;
        fb_wr.data = 8'h00;
      end
      ST_WR0: begin
        fb_wr.we = g_q.vld0;
      end
      ST_RD1: begin
        fb_raddr = g_q.addr1;
      end
      ST_WR1: begin
        fb_wr.we   = g_q.vld1;
        fb_wr.addr = g_q.addr1;
      end
      ST_QRD: begin
        fb_raddr = qaddr;
      end
      ST_ORD: begin
        fb_raddr = oaddr;
      end
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      w_q    <= sprite_w_i;
      h_q    <= sprite_h_i;
      mode_q <= color_mode_i;
      mir_q  <= mirror_i;
      c_q    <= bitmap_col_i;
      band_q <= bitmap_row_i;
      px_q   <= pixels_i;
      last_q <= last_i;
      qcol_q <= pos_x_i;
      qcnt_q <= sprite_w_i;
    end
    if (state_q == ST_DECODE) begin
      g_q <= geom;
    end
    case (state_q)
      ST_WR1: begin
        res_coll_q  <= 32'(coll_acc_d);
        res_white_q <= 1'b0;
        res_read_q  <= 8'h00;
      end
      ST_QRD: begin
        res_coll_q  <= 32'h0;
        res_white_q <= 1'b0;
        res_read_q  <= 8'h00;
      end
      ST_QCHK: begin
        res_white_q <= blend_hit;
        qcol_q      <= qcol_q + 8'd1;
        qcnt_q      <= qcnt_q - 7'd1;
      end
      ST_OCHK: begin
        res_coll_q  <= 32'h0;
        res_white_q <= 1'b0;
        res_read_q  <= o_in_range ? fb_rdata : 8'h00;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      coll_acc_q  <= '0;
      out_valid_q <= 1'b0;
      coll_mask_q <= 32'h0;
      white_q     <= 1'b0;
      read_data_q <= 8'h00;
    end else begin
      // The response step handles its own output transfer.
      if (out_valid_q && out_ready_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == FB_AW'(FB_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            case (operation_i)
              OP_DRAW:  state_q <= ST_DECODE;
              OP_QUERY: state_q <= ST_QRD;
              OP_READ:  state_q <= ST_ORD;
              default:  state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DECODE: state_q <= ST_RD0;
        ST_RD0:    state_q <= ST_WR0;
        ST_WR0: begin
          coll_acc_q <= coll_acc_d;
          state_q    <= ST_RD1;
        end
        ST_RD1:    state_q <= ST_WR1;
        ST_WR1: begin
          if (last_q) begin
            coll_acc_q <= '0;
            state_q    <= ST_RESP;
          end else begin
            coll_acc_q <= coll_acc_d;
            state_q    <= ST_IDLE;
          end
        end
        ST_QRD: begin
          state_q <= q_stop ? ST_RESP : ST_QCHK;
        end
        ST_QCHK: begin
          state_q <= blend_hit ? ST_RESP : ST_QRD;
        end
        ST_ORD:    state_q <= ST_OCHK;
        ST_OCHK:   state_q <= ST_RESP;
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            coll_mask_q <= res_coll_q;
            white_q     <= res_white_q;
            read_data_q <= res_read_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign collision_mask_o = coll_mask_q;
  assign white_found_o    = white_q;
  assign read_data_o      = read_data_q;

  // The buffer is written only by the clearing sweep and the two draw write steps.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_wr.we |-> (state_q == ST_CLEAR || state_q == ST_WR0 || state_q == ST_WR1))
    else $error("frame buffer written outside a write step");

  // A new result appears only from the response step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside the response step");

  // The last byte of a sprite leaves the collision accumulator empty.
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR1 && last_q) |=> (coll_acc_q == '0))
    else $error("collision accumulator not cleared after last byte");

  // The query test step is entered only with columns left in the span.
  a_query_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QCHK) |-> (qcnt_q != 7'd0 && qcol_q < 8'(SCREEN_WIDTH)))
    else $error("row query stepped past its span");

  // The output register is never overwritten while it holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !out_ready_i) |=> (state_q == ST_RESP))
    else $error("response step left while the output was stalled");

endmodule

`default_nettype wire

// ===== bench/page_framebuffer_sprite_blitter_test.sv =====
// Self-checking testbench for the page frame buffer sprite blitter.
`timescale 1ns / 1ps

module page_framebuffer_sprite_blitter_test;
  import pfsb_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int ITEM_TARGET   = 2000;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int PRESSURE_AT   = 600;
  localparam int PRESSURE_LEN  = 400;

  typedef struct {
    logic [1:0]        op;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [6:0]        spr_w;
    logic [6:0]        spr_h;
    logic [1:0]        mode;
    logic              mirror;
    logic [6:0]        col;
    logic [3:0]        band;
    logic [7:0]        pixels;
    logic              last;
  } blit_item_t;

  typedef struct {
    logic [31:0] mask;
    logic        white;
    logic [7:0]  rdata;
  } blit_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic signed [7:0] pos_x = '0;
  logic signed [7:0] pos_y = '0;
  logic [6:0] sprite_w = '0;
  logic [6:0] sprite_h = '0;
  logic [1:0] color_mode = '0;
  logic mirror = 1'b0;
  logic [6:0] bitmap_col = '0;
  logic [3:0] bitmap_row = '0;
  logic [7:0] pixels = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] collision_mask;
  logic white_found;
  logic [7:0] read_data;

  blit_item_t items_to_send[$];
  blit_reply_t replies_due[$];
  blit_item_t cur_item;
  logic [7:0] shadow_fb [FB_DEPTH];
  logic [31:0] shadow_hits;

  bit in_taken = 1'b0;
  int items_accepted = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int calm_sends = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit held_off = 1'b0;

  page_framebuffer_sprite_blitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .sprite_w_i      (sprite_w),
    .sprite_h_i      (sprite_h),
    .color_mode_i    (color_mode),
    .mirror_i        (mirror),
    .bitmap_col_i    (bitmap_col),
    .bitmap_row_i    (bitmap_row),
    .pixels_i        (pixels),
    .last_i          (last),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .collision_mask_o(collision_mask),
    .white_found_o   (white_found),
    .read_data_o     (read_data)
  );

  always #2 clk_i = ~clk_i;

  // Combine one shifted byte into one buffer cell and report overlap with set pixels.
  function automatic bit blend_cell(input int page, input int col, input logic [7:0] bits,
                                    input logic [1:0] mode);
    int a;
    bit hit;
    if (page < 0 || page >= PAGES || col < 0 || col >= SCREEN_WIDTH) return 1'b0;
    a = page * SCREEN_WIDTH + col;
    hit = (shadow_fb[a] & bits) != 8'd0;
    case (mode)
      MODE_SET:    shadow_fb[a] = shadow_fb[a] | bits;
      MODE_CLEAR:  shadow_fb[a] = shadow_fb[a] & ~bits;
      MODE_INVERT: shadow_fb[a] = shadow_fb[a] ^ bits;
      default: ;
    endcase
    return hit;
  endfunction

  function automatic void shadow_draw(input blit_item_t it);
    int x, y, w, h, c_idx, band_idx, bands, base, off, page, col;
    logic [7:0] lo_bits, hi_bits;
    bit hit;
    x = it.pos_x;
    y = it.pos_y;
    w = it.spr_w;
    h = it.spr_h;
    c_idx = it.col;
    band_idx = it.band;
    if (x + w < 0 || y + h < 0 || y > SCREEN_HEIGHT - 1) return;
    bands = (h + 7) / 8;
    if (c_idx >= w || band_idx >= bands) return;
    // Page index rounds toward minus infinity so that negative rows shift correctly.
    base = (y >= 0) ? y / 8 : -((-y + 7) / 8);
    off = y - base * 8;
    page = base + band_idx;
    col = x + (it.mirror ? (w - 1 - c_idx) : c_idx);
    if (col < 0 || col >= SCREEN_WIDTH) return;
    lo_bits = it.pixels << off;
    hit = blend_cell(page, col, lo_bits, it.mode);
    if (off != 0) begin
      hi_bits = it.pixels >> (8 - off);
      if (blend_cell(page + 1, col, hi_bits, it.mode)) hit = 1'b1;
    end
    if (hit && c_idx < COLLISION_BITS) shadow_hits[c_idx] = 1'b1;
  endfunction

  function automatic bit row_has_white(input blit_item_t it);
    int qx, qy, span, page;
    logic [7:0] row_bit;
    qx = {24'd0, it.pos_x};
    qy = {24'd0, it.pos_y};
    span = it.spr_w;
    if (qy >= SCREEN_HEIGHT) return 1'b0;
    page = qy / PAGE_ROWS;
    row_bit = 8'd1 << (qy % PAGE_ROWS);
    for (int i = 0; i < span; i++) begin
      if (qx + i >= SCREEN_WIDTH) break;
      if ((shadow_fb[page * SCREEN_WIDTH + qx + i] & row_bit) != 8'd0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_reply(input blit_item_t it, output blit_reply_t r);
    r.mask = '0;
    r.white = 1'b0;
    r.rdata = '0;
    case (it.op)
      OP_DRAW: begin
        shadow_draw(it);
        if (!it.last) return 1'b0;
        r.mask = shadow_hits;
        shadow_hits = '0;
        return 1'b1;
      end
      OP_QUERY: begin
        r.white = row_has_white(it);
        return 1'b1;
      end
      OP_READ: begin
        if (it.band < PAGES) r.rdata = shadow_fb[it.band * SCREEN_WIDTH + it.col];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic queue_item(input int op, x, y, w, h, mode, mir, c, band, px, fin);
    blit_item_t it;
    it.op = 2'(op);
    it.pos_x = 8'(x);
    it.pos_y = 8'(y);
    it.spr_w = 7'(w);
    it.spr_h = 7'(h);
    it.mode = 2'(mode);
    it.mirror = 1'(mir);
    it.col = 7'(c);
    it.band = 4'(band);
    it.pixels = 8'(px);
    it.last = 1'(fin);
    items_to_send.push_back(it);
  endtask

  // Fields that a query or a readout ignores are filled with noise.
  task automatic queue_query(input int x, y, w);
    queue_item(OP_QUERY, x, y, w, $urandom_range(0, 127), $urandom_range(0, 3),
               $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 15),
               $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic queue_read(input int c, page);
    queue_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127),
               $urandom_range(0, 127), $urandom_range(0, 3), $urandom_range(0, 1), c, page,
               $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // One sprite as a sequence of draw bytes, now and then broken on purpose.
  task automatic queue_sprite();
    int r, x, y, w, h, bands, total, c, b, mode, mir;
    bit drop_last, full_walk;
    r = $urandom_range(0, 99);
    w = (r < 80) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 127);
    if ($urandom_range(0, 29) == 0) w = 0;
    h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(0, 127);
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128 : $urandom_range(0, 150) - 24;
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128 : $urandom_range(0, 82) - 12;
    r = $urandom_range(0, 99);
    mode = (r < 40) ? MODE_SET : (r < 65) ? MODE_INVERT : (r < 85) ? MODE_CLEAR : MODE_KEEP;
    mir = $urandom_range(0, 1);
    bands = (h + 7) / 8;
    drop_last = $urandom_range(0, 99) < 6;
    if ($urandom_range(0, 99) < 5)
      queue_item(OP_DRAW, x, y, w, h, mode, mir, $urandom_range(w, 127), $urandom_range(0, 15),
                 $urandom_range(0, 255), 0);
    full_walk = (w * bands > 0) && (w * bands <= 16);
    total = full_walk ? w * bands : $urandom_range(1, 10);
    for (int i = 0; i < total; i++) begin
      if (full_walk) begin
        c = i / bands;
        b = i % bands;
      end else begin
        c = $urandom_range(0, (w > 0) ? w - 1 : 0);
        b = $urandom_range(0, (bands > 0) ? bands - 1 : 0);
      end
      queue_item(OP_DRAW, x, y, w, h, mode, mir, c, b, $urandom_range(0, 255),
                 (i == total - 1) && !drop_last);
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: holds each item until it is transferred, then waits out a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (items_to_send.size() != 0) begin
        cur_item = items_to_send.pop_front();
        operation <= cur_item.op;
        pos_x <= cur_item.pos_x;
        pos_y <= cur_item.pos_y;
        sprite_w <= cur_item.spr_w;
        sprite_h <= cur_item.spr_h;
        color_mode <= cur_item.mode;
        mirror <= cur_item.mirror;
        bitmap_col <= cur_item.col;
        bitmap_row <= cur_item.band;
        pixels <= cur_item.pixels;
        last <= cur_item.last;
        in_valid <= 1'b1;
        if (calm_sends > 0) begin
          calm_sends--;
          send_gap = 0;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 59) == 0) calm_sends = $urandom_range(20, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (!held_off && items_accepted >= PRESSURE_AT) begin
      hold_left = PRESSURE_LEN;
      held_off = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = ($urandom_range(0, 99) < 15) ? idle_len() : 0;
    end
  end

  always @(posedge clk_i) begin : check_results
    blit_reply_t fresh;
    blit_reply_t want;
    in_taken = in_valid && in_ready;
    if (in_taken) begin
      items_accepted++;
      if (predict_reply(cur_item, fresh)) replies_due.push_back(fresh);
    end
    if (out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing expected: mask %h white %b data %h",
                 $time, collision_mask, white_found, read_data);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (collision_mask !== want.mask) begin
          $display("%0t: collision_mask expected %h, got %h", $time, want.mask, collision_mask);
          fail_count++;
        end
        if (white_found !== want.white) begin
          $display("%0t: white_found expected %b, got %b", $time, want.white, white_found);
          fail_count++;
        end
        if (read_data !== want.rdata) begin
          $display("%0t: read_data expected %h, got %h", $time, want.rdata, read_data);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int r;
    int items_total;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    shadow_hits = '0;

    // Directed: set and re-set one cell, clipping at every edge, each color mode,
    // mirroring, collision columns past the mask, off-screen sprites, bytes outside
    // the sprite, out-of-range readouts and the unused operation.
    queue_read(0, 0);
    queue_item(OP_DRAW, 0, 0, 1, 8, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_item(OP_DRAW, 0, 0, 1, 8, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_read(0, 0);
    queue_query(0, 0, 1);
    queue_query(0, 64, 5);
    queue_query(0, 255, 127);
    queue_query(200, 0, 10);
    queue_item(OP_DRAW, 127, -3, 1, 8, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_query(120, 0, 127);
    queue_item(OP_DRAW, 5, 60, 1, 8, MODE_INVERT, 0, 0, 0, 8'hAA, 1);
    queue_read(5, 7);
    queue_item(OP_DRAW, 0, 0, 1, 8, MODE_KEEP, 0, 0, 0, 8'h0F, 1);
    queue_item(OP_DRAW, 0, 0, 1, 8, MODE_CLEAR, 1, 0, 0, 8'h0F, 1);
    queue_read(0, 0);
    queue_item(OP_DRAW, 10, 8, 40, 8, MODE_SET, 1, 35, 0, 8'hFF, 0);
    queue_item(OP_DRAW, 10, 8, 40, 8, MODE_SET, 1, 35, 0, 8'hFF, 1);
    queue_item(OP_DRAW, -128, 0, 5, 8, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_item(OP_DRAW, 0, 64, 5, 8, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_item(OP_DRAW, 0, -20, 5, 10, MODE_SET, 0, 0, 0, 8'hFF, 1);
    queue_item(OP_DRAW, 0, 0, 5, 16, MODE_SET, 0, 5, 2, 8'hFF, 1);
    queue_read(127, 15);
    queue_item(OP_NONE, 127, 127, 127, 127, MODE_KEEP, 1, 127, 15, 8'hFF, 1);
    queue_item(OP_DRAW, -100, -100, 127, 127, MODE_SET, 0, 120, 15, 8'hFF, 1);
    queue_read(20, 2);

    while (items_to_send.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 62)
        queue_sprite();
      else if (r < 80)
        queue_query(($urandom_range(0, 9) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127),
                    ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63) : $urandom_range(64, 255),
                    ($urandom_range(0, 99) < 88) ? $urandom_range(1, 16) : $urandom_range(0, 127));
      else if (r < 92)
        queue_read($urandom_range(0, 127),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7));
      else
        queue_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3),
                   $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 15),
                   $urandom_range(0, 255), $urandom_range(0, 1));
    end
    items_total = items_to_send.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_accepted < items_total) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
